>>> rtl/gp_pkg.sv
package gp_pkg;

  localparam int FREQ_BITS = 16;
  localparam int MAX_CLASSES_DEF = 64;
  localparam int PCT_SCALE = 100;
  localparam int RANK_MAX = 99;
  localparam int WIDTH_BITS = 31;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_QUERY = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_EMPTY   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_LOWER_LIMIT = 2'd0,
    REG_CLASS_WIDTH = 2'd1,
    REG_CLASS_COUNT = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [1:0]           action;
    logic [FREQ_BITS-1:0] class_frequency;
    logic [6:0]           percentile_rank;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] percentile_value;
    logic [1:0]         status;
  } result_t;

endpackage

>>> rtl/gp_mem.sv
module gp_mem #(
  parameter int DEPTH = 64,
  parameter int AW = 6,
  parameter int DW = 22
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/gp_div.sv
// Bit-serial scaled quotient floor(diff * w / den), diff <= den.
// Each bit of w takes an accumulate step (D_ADD) and a reduce step (D_SUB).
module gp_div #(
  parameter int DW = 29
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [DW-1:0]                    diff,
  input  logic [DW-1:0]                    den,
  input  logic [gp_pkg::WIDTH_BITS-1:0]    w,
  output logic                             done,
  output logic [gp_pkg::WIDTH_BITS-1:0]    q,
  output logic                             inexact
);
  import gp_pkg::*;

  localparam int KW = $clog2(WIDTH_BITS);

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_ADD  = 3'b010,
    D_SUB  = 3'b100
  } dstate_t;

  dstate_t         state;
  logic [DW+1:0]   rem;
  logic [DW:0]     den2;
  logic [DW-1:0]   den_r;
  logic [DW-1:0]   diff_r;
  logic [WIDTH_BITS-1:0] w_r;
  logic [KW-1:0]   k;

  assign inexact = (rem != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        D_IDLE: begin
          if (start) begin
            q      <= '0;
            rem    <= '0;
            den_r  <= den;
            den2   <= {den, 1'b0};
            diff_r <= diff;
            w_r    <= w;
            k      <= KW'(WIDTH_BITS - 1);
            if (den == '0) begin
              done <= 1'b1;
            end else begin
              state <= D_ADD;
            end
          end
        end
        D_ADD: begin
          rem   <= {rem[DW:0], 1'b0} + (w_r[k] ? (DW+2)'(diff_r) : '0);
          state <= D_SUB;
        end
        D_SUB: begin
          if (rem >= (DW+2)'(den2)) begin
            rem <= rem - (DW+2)'(den2);
            q   <= {q[WIDTH_BITS-2:0], 1'b0} + WIDTH_BITS'(2);
          end else if (rem >= (DW+2)'(den_r)) begin
            rem <= rem - (DW+2)'(den_r);
            q   <= {q[WIDTH_BITS-2:0], 1'b0} + WIDTH_BITS'(1);
          end else begin
            q   <= {q[WIDTH_BITS-2:0], 1'b0};
          end
          if (k == '0) begin
            done  <= 1'b1;
            state <= D_IDLE;
          end else begin
            k     <= k - 1'b1;
            state <= D_ADD;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/grouped_percentile_core.sv
// Channel   Direction  Handshake                     Payload
// command   in         start high while busy low     cmd (action, frequency, rank)
// result    out        done strobe, one cycle        result (value, status)
// config    in         APB write, pready always high three registers at 0, 4, 8
//
// Clear and load complete on the transfer and leave the block ready for the next
// transfer. A query with classes missing strobes done in the next cycle, one with
// an empty total from S_TOTAL. Otherwise S_TOTAL leads to S_READ and S_CMP per
// scanned class up to the class found c, setup, the divider (which returns at
// once when class c is empty) and the final add. Reset (rst, synchronous)
// empties the histogram count, not the memory. The receiver cannot stall results.
module grouped_percentile_core #(
  parameter int MAX_CLASSES = gp_pkg::MAX_CLASSES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  gp_pkg::cmd_t    cmd,
  output logic            done,
  output gp_pkg::result_t result,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [3:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import gp_pkg::*;

  // Address width of the cumulative store, count width able to hold MAX_CLASSES,
  // cumulative count width, and the width of values scaled by one hundred.
  localparam int AW  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int NW  = $clog2(MAX_CLASSES + 1);
  localparam int CW  = FREQ_BITS + AW;
  localparam int DW  = CW + 7;
  localparam int BW  = AW + WIDTH_BITS;
  localparam int VW  = AW + 34;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_TOTAL  = 10'b0000000010,
    S_READ   = 10'b0000000100,
    S_CMP    = 10'b0000001000,
    S_PREP1  = 10'b0000010000,
    S_PREP2  = 10'b0000100000,
    S_LAUNCH = 10'b0001000000,
    S_WAIT   = 10'b0010000000,
    S_FIN1   = 10'b0100000000,
    S_FIN2   = 10'b1000000000
  } state_t;

  // Configuration registers.
  logic signed [31:0]    first_lower_limit;
  logic [WIDTH_BITS-1:0] class_width;
  logic [6:0]            class_count;

  state_t          state;
  logic [NW-1:0]   loaded;
  logic [CW-1:0]   last_cum;
  logic [NW-1:0]   n_eff;
  logic [6:0]      rank;
  logic [DW-1:0]   target;
  logic [AW-1:0]   cls;
  logic [CW-1:0]   prev;
  logic [CW-1:0]   cur;
  logic [CW-1:0]   freq;
  logic [DW-1:0]   prev100;
  logic [DW-1:0]   diff;
  logic [DW-1:0]   den;
  logic [BW-1:0]   cls_width;
  logic signed [VW-1:0] sum;
  logic signed [VW-1:0] adj;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [CW-1:0]   mem_wdata;
  logic [AW-1:0]   mem_raddr;
  logic [CW-1:0]   mem_rdata;

  logic            div_start;
  logic            div_done;
  logic [WIDTH_BITS-1:0] div_q;
  logic            div_inexact;

  logic            accept;
  logic [6:0]      rank_in;
  logic            hit;

  assign pready = 1'b1;
  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Configuration writes complete in the access phase of an APB transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_lower_limit <= '0;
      class_width       <= WIDTH_BITS'(256);
      class_count       <= 7'd1;
    end else if (psel && penable && pwrite) begin
      case (reg_index_t'(paddr[3:2]))
        REG_LOWER_LIMIT: first_lower_limit <= pwdata;
        REG_CLASS_WIDTH: class_width       <= pwdata[WIDTH_BITS-1:0];
        REG_CLASS_COUNT: class_count       <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index_t'(paddr[3:2]))
      REG_LOWER_LIMIT: prdata = first_lower_limit;
      REG_CLASS_WIDTH: prdata = 32'(class_width);
      REG_CLASS_COUNT: prdata = 32'(class_count);
      default:         prdata = '0;
    endcase
  end

  // The class count is clamped into one through MAX_CLASSES.
  always_comb begin
    if (class_count == '0) begin
      n_eff = NW'(1);
    end else if (32'(class_count) > 32'(MAX_CLASSES)) begin
      n_eff = NW'(MAX_CLASSES);
    end else begin
      n_eff = NW'(class_count);
    end
  end

  always_comb begin
    if (cmd.percentile_rank == '0) begin
      rank_in = 7'd1;
    end else if (cmd.percentile_rank > 7'(RANK_MAX)) begin
      rank_in = 7'(RANK_MAX);
    end else begin
      rank_in = cmd.percentile_rank;
    end
  end

  // A load appends to the running total kept in last_cum, so it needs no read.
  assign mem_we    = accept && (action_t'(cmd.action) == ACT_LOAD) && (loaded < n_eff);
  assign mem_waddr = loaded[AW-1:0];
  assign mem_wdata = last_cum + CW'(cmd.class_frequency);

  // The total lives in the last class in use; the scan reads one class a step.
  assign mem_raddr = (state == S_IDLE) ? AW'(n_eff - 1'b1) : cls;

  assign hit = (DW'(mem_rdata) * DW'(PCT_SCALE) >= target) ||
               (NW'(cls) == n_eff - 1'b1);

  assign div_start = (state == S_LAUNCH);

  always_comb begin
    adj = sum;
    if (div_inexact && sum[VW-1]) begin
      adj = sum + VW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      loaded   <= '0;
      last_cum <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (action_t'(cmd.action))
              ACT_CLEAR: begin
                loaded   <= '0;
                last_cum <= '0;
              end
              ACT_LOAD: begin
                if (mem_we) begin
                  loaded   <= loaded + 1'b1;
                  last_cum <= mem_wdata;
                end
              end
              ACT_QUERY: begin
                rank <= rank_in;
                if (loaded < n_eff) begin
                  result.percentile_value <= '0;
                  result.status           <= ST_MISSING;
                  done                    <= 1'b1;
                end else begin
                  state <= S_TOTAL;
                end
              end
              default: ;
            endcase
          end
        end
        S_TOTAL: begin
          if (mem_rdata == '0) begin
            result.percentile_value <= '0;
            result.status           <= ST_EMPTY;
            done                    <= 1'b1;
            state                   <= S_IDLE;
          end else begin
            target <= DW'(rank) * DW'(mem_rdata);
            cls    <= '0;
            prev   <= '0;
            state  <= S_READ;
          end
        end
        S_READ: state <= S_CMP;
        S_CMP: begin
          if (hit) begin
            cur   <= mem_rdata;
            state <= S_PREP1;
          end else begin
            prev  <= mem_rdata;
            cls   <= cls + 1'b1;
            state <= S_READ;
          end
        end
        S_PREP1: begin
          freq    <= cur - prev;
          prev100 <= DW'(prev) * DW'(PCT_SCALE);
          state   <= S_PREP2;
        end
        S_PREP2: begin
          diff      <= target - prev100;
          den       <= DW'(freq) * DW'(PCT_SCALE);
          cls_width <= BW'(cls) * BW'(class_width);
          state     <= S_LAUNCH;
        end
        S_LAUNCH: state <= S_WAIT;
        S_WAIT: begin
          if (div_done) begin
            state <= S_FIN1;
          end
        end
        S_FIN1: begin
          sum   <= VW'(first_lower_limit) + VW'(cls_width) + VW'(div_q);
          state <= S_FIN2;
        end
        S_FIN2: begin
          // Saturate to the signed 32-bit range.
          if (adj[VW-1:31] == '0 || adj[VW-1:31] == '1) begin
            result.percentile_value <= adj[31:0];
          end else if (adj[VW-1]) begin
            result.percentile_value <= 32'sh8000_0000;
          end else begin
            result.percentile_value <= 32'sh7fff_ffff;
          end
          result.status <= ST_OK;
          done          <= 1'b1;
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  gp_mem #(
    .DEPTH(MAX_CLASSES),
    .AW(AW),
    .DW(CW)
  ) u_mem (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  gp_div #(
    .DW(DW)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .diff(diff),
    .den(den),
    .w(class_width),
    .done(div_done),
    .q(div_q),
    .inexact(div_inexact)
  );

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for grouped_percentile_core. A stimulus process fills
// a queue of commands and programs the registers between phases. A clocked
// driver presents those commands with random gaps, and a clocked monitor
// predicts each query answer at acceptance and checks the done strobes.
module tb_top;
  import gp_pkg::*;

  localparam int NCLS = 64;
  localparam int DRAIN_CYCLES = 260;    // longest query plus margin
  localparam int CYCLE_LIMIT = 2000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  cmd_t        cmd = '0;
  logic        done;
  result_t     result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  grouped_percentile_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .done(done),
    .result(result), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // Shadow of the histogram and the registers, kept in step with the block.
  longint unsigned hist_cum [NCLS];
  int unsigned     hist_loaded;
  logic signed [31:0] limit_q8;
  logic [30:0]     width_q8;
  logic [6:0]      count_reg;

  cmd_t    cmd_queue[$];
  result_t answers_due[$];
  int      fail_count = 0;
  int      cycle_count = 0;
  int      gap_left = 0;
  bit      gaps_on = 1'b1;
  bit      took;

  // Applies one command to the shadow histogram; a query yields an answer.
  task automatic histogram_step(input cmd_t c, output bit has_answer,
                                output result_t answer);
    int unsigned n, k, cls;
    longint unsigned rank, total, target, prev, freq, diff, den, quo, rem;
    longint val;
    has_answer = 1'b0;
    answer = '0;
    n = (count_reg == 0) ? 1 : (count_reg > NCLS) ? NCLS : count_reg;
    case (c.action)
      ACT_CLEAR: hist_loaded = 0;
      ACT_LOAD: begin
        if (hist_loaded < n) begin
          prev = (hist_loaded != 0) ? hist_cum[hist_loaded-1] : 0;
          hist_cum[hist_loaded] = prev + c.class_frequency;
          hist_loaded++;
        end
      end
      ACT_QUERY: begin
        has_answer = 1'b1;
        rank = c.percentile_rank;
        if (rank < 1) rank = 1;
        if (rank > RANK_MAX) rank = RANK_MAX;
        if (hist_loaded < n) begin
          answer.status = ST_MISSING;
        end else if (hist_cum[n-1] == 0) begin
          answer.status = ST_EMPTY;
        end else begin
          total = hist_cum[n-1];
          target = rank * total;
          cls = 0;
          while (cls + 1 < n && hist_cum[cls] * PCT_SCALE < target) cls++;
          prev = (cls != 0) ? hist_cum[cls-1] : 0;
          freq = hist_cum[cls] - prev;
          diff = target - prev * PCT_SCALE;
          den = freq * PCT_SCALE;
          quo = 0;
          rem = 0;
          // Bit-serial scaling of the in-class offset by the class width.
          if (den != 0) begin
            for (k = 31; k > 0; k--) begin
              rem = rem << 1;
              quo = quo << 1;
              if (width_q8[k-1]) rem += diff;
              while (rem >= den) begin
                rem -= den;
                quo++;
              end
            end
          end
          val = longint'(limit_q8) + longint'(cls) * longint'(width_q8)
                + longint'(quo);
          // Truncation toward zero for negative values.
          if (rem != 0 && val < 0) val += 1;
          if (val > 64'sd2147483647) val = 64'sd2147483647;
          if (val < -64'sd2147483648) val = -64'sd2147483648;
          answer.percentile_value = val[31:0];
          answer.status = ST_OK;
        end
      end
      default: ;
    endcase
  endtask

  // Monitor: predicts at each accepted command and checks each strobe.
  always @(posedge clk) begin
    bit has_answer;
    result_t answer;
    result_t want;
    took <= !rst && start && !busy;
    if (!rst && done) begin
      if (answers_due.size() == 0) begin
        $error("result with no query outstanding: value %0d status %0d",
               result.percentile_value, result.status);
        fail_count++;
      end else begin
        want = answers_due.pop_front();
        if (result.percentile_value !== want.percentile_value) begin
          $error("percentile_value: expected %0d actual %0d",
                 want.percentile_value, result.percentile_value);
          fail_count++;
        end
        if (result.status !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, result.status);
          fail_count++;
        end
      end
    end
    if (!rst && start && !busy) begin
      histogram_step(cmd, has_answer, answer);
      if (has_answer) answers_due.push_back(answer);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: start stays high until the transfer is taken, then the next
  // command follows after a random gap.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !took) begin
      start <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left--;
      start <= 1'b0;
    end else if (cmd_queue.size() > 0) begin
      cmd <= cmd_queue.pop_front();
      start <= 1'b1;
      gap_left = pick_gap();
    end else begin
      start <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic reg_write(input reg_index_t idx, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 4'(idx) << 2;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_LOWER_LIMIT: limit_q8 = data;
      REG_CLASS_WIDTH: width_q8 = data[30:0];
      default:         count_reg = data[6:0];
    endcase
  endtask

  // Waits until every command has been taken and every answer checked, then
  // waits out the DRAIN_CYCLES margin.
  task automatic wait_quiet();
    while (cmd_queue.size() != 0 || start || answers_due.size() != 0 || busy)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic cmd_t make_cmd(input action_t a, input int f, input int r);
    cmd_t c;
    c.action = a;
    c.class_frequency = f[FREQ_BITS-1:0];
    c.percentile_rank = r[6:0];
    return c;
  endfunction

  function automatic int rand_freq();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 65535;
      2: return $urandom_range(0, 20);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic int rand_rank();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                       : $urandom_range(1, 99);
  endfunction

  initial begin
    int sent;
    int n;
    int loads;
    logic [31:0] lim;
    logic [31:0] wid;
    logic [6:0] cnt;
    int edge_ranks[6];
    edge_ranks = '{0, 1, 50, 99, 100, 127};
    hist_loaded = 0;
    limit_q8 = 0;
    width_q8 = 31'd256;
    count_reg = 7'd1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part with the reset register values: missing class, empty
    // total, rank clamping at both ends, the unused action and an extra load.
    cmd_queue.push_back(make_cmd(ACT_QUERY, 0, 50));
    cmd_queue.push_back(make_cmd(ACT_LOAD, 0, 0));
    cmd_queue.push_back(make_cmd(ACT_QUERY, 0, 1));
    cmd_queue.push_back(make_cmd(ACT_CLEAR, 65535, 127));
    cmd_queue.push_back(make_cmd(ACT_LOAD, 65535, 0));
    cmd_queue.push_back(make_cmd(ACT_LOAD, 12, 0));
    cmd_queue.push_back(make_cmd(action_t'(2'd3), 65535, 127));
    foreach (edge_ranks[i])
      cmd_queue.push_back(make_cmd(ACT_QUERY, 0, edge_ranks[i]));
    wait_quiet();

    // Most negative limit, zero width, several classes.
    reg_write(REG_LOWER_LIMIT, 32'h8000_0000);
    reg_write(REG_CLASS_WIDTH, 32'd0);
    reg_write(REG_CLASS_COUNT, 32'd3);
    cmd_queue.push_back(make_cmd(ACT_CLEAR, 0, 0));
    cmd_queue.push_back(make_cmd(ACT_LOAD, 5, 0));
    cmd_queue.push_back(make_cmd(ACT_LOAD, 0, 0));
    cmd_queue.push_back(make_cmd(ACT_LOAD, 5, 0));
    cmd_queue.push_back(make_cmd(ACT_QUERY, 0, 50));
    cmd_queue.push_back(make_cmd(ACT_QUERY, 0, 99));
    wait_quiet();
    sent = 19;

    // Random phases: a register setting, then a well-formed histogram with
    // random content and queries, with some broken sequences mixed in.
    while (sent < 400) begin
      gaps_on = ($urandom_range(0, 4) != 0);
      case ($urandom_range(0, 5))
        0: lim = 32'h8000_0000;
        1: lim = 32'h7FFF_FFFF;
        2: lim = 32'd0;
        default: lim = $urandom();
      endcase
      case ($urandom_range(0, 6))
        0: wid = 32'd0;
        1: wid = 32'd1;
        2: wid = 32'h7FFF_FFFF;
        3: wid = $urandom() & 32'h7FFF_FFFF;
        default: wid = $urandom_range(1, 8192);
      endcase
      case ($urandom_range(0, 9))
        0: cnt = 7'd0;
        1: cnt = 7'd64;
        2: cnt = 7'd127;
        3: cnt = $urandom_range(65, 126);
        default: cnt = $urandom_range(1, 8);
      endcase
      reg_write(REG_LOWER_LIMIT, lim);
      reg_write(REG_CLASS_WIDTH, wid);
      reg_write(REG_CLASS_COUNT, {25'd0, cnt});
      n = (cnt == 0) ? 1 : (cnt > NCLS) ? NCLS : cnt;
      loads = n;
      if ($urandom_range(0, 5) == 0) loads = n - 1;
      else if ($urandom_range(0, 5) == 0) loads = n + 2;
      cmd_queue.push_back(make_cmd(ACT_CLEAR, $urandom_range(0, 65535),
                                   $urandom_range(0, 127)));
      for (int i = 0; i < loads; i++)
        cmd_queue.push_back(make_cmd(ACT_LOAD, rand_freq(), $urandom_range(0, 127)));
      if ($urandom_range(0, 3) == 0)
        cmd_queue.push_back(make_cmd(action_t'(2'd3), $urandom_range(0, 65535),
                                     $urandom_range(0, 127)));
      for (int i = $urandom_range(3, 8); i > 0; i--)
        cmd_queue.push_back(make_cmd(ACT_QUERY, $urandom_range(0, 65535), rand_rank()));
      sent += cmd_queue.size();
      wait_quiet();
    end

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/gp_pkg.sv
rtl/gp_mem.sv
rtl/gp_div.sv
rtl/grouped_percentile_core.sv
verif/tb_top.sv
